[sv/tsalu_pkg.sv]
// Shared constants, codes and types for the two-stack integer ALU.
package tsalu_pkg;
   localparam int DATA_DEPTH    = 256;
   localparam int CONTROL_DEPTH = 128;
   localparam int DCW = $clog2(DATA_DEPTH + 1);
   localparam int CCW = $clog2(CONTROL_DEPTH + 1);
   localparam int DAW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
   localparam int CAW = (CONTROL_DEPTH > 1) ? $clog2(CONTROL_DEPTH) : 1;
   localparam int WORD = 32;

   typedef logic [DCW-1:0]  dcount_type;
   typedef logic [CCW-1:0]  ccount_type;
   typedef logic [WORD-1:0] word_type;

   typedef enum logic [3:0] {
      OP_PUSH = 4'd0, OP_DROP = 4'd1, OP_DUP = 4'd2, OP_SWAP = 4'd3,
      OP_ADD = 4'd4, OP_SUB = 4'd5, OP_MUL = 4'd6, OP_DIV = 4'd7,
      OP_LT = 4'd8, OP_ULT = 4'd9, OP_NOT = 4'd10, OP_TOCTL = 4'd11,
      OP_FROMCTL = 4'd12, OP_EMIT = 4'd13
   } op_type;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_RDI   = 9'b000000010,
      ST_RDJ   = 9'b000000100,
      ST_CALC  = 9'b000001000,
      ST_DIV   = 9'b000010000,
      ST_WR1   = 9'b000100000,
      ST_WR2   = 9'b001000000,
      ST_RDTOP = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;
endpackage

[sv/tsalu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsalu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic                                        re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

[sv/tsalu_div.sv]
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module tsalu_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  tsalu_pkg::word_type   dividend,
   input  tsalu_pkg::word_type   divisor,
   output logic                  done,
   output tsalu_pkg::word_type   quotient
);
   import tsalu_pkg::*;

   logic [WORD:0]  rem_ff, rem_in;
   word_type       q_ff, q_in;
   word_type       d_ff, d_in;
   logic           neg_ff, neg_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic           done_ff, done_in;
   logic [WORD:0]  rem_sh;
   logic [WORD:0]  diff;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[WORD-1:0], q_ff[WORD-1]};
      diff    = rem_sh - {1'b0, d_ff};
      if (start) begin
         neg_in = dividend[WORD-1] ^ divisor[WORD-1];
         q_in   = dividend[WORD-1] ? (word_type'(0) - dividend) : dividend;
         d_in   = divisor[WORD-1] ? (word_type'(0) - divisor) : divisor;
         rem_in = '0;
         cnt_in = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         if (!diff[WORD]) begin
            rem_in = diff;
         end else begin
            rem_in = rem_sh;
         end
         q_in    = {q_ff[WORD-2:0], ~diff[WORD]};
         cnt_in  = cnt_ff - 6'd1;
         done_in = (cnt_ff == 6'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (word_type'(0) - q_ff) : q_ff;

   a_done_after_count: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(cnt_ff) == 6'd1)
      else $error("divider done without finishing its bit steps");
   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      start |=> cnt_ff == 6'd32)
      else $error("divider start did not load the step count");
   a_no_done_on_start: assert property (@(posedge clock) disable iff (reset)
      start |=> !done_ff)
      else $error("divider done raised right after start");
endmodule

[sv/two_stack_integer_alu.sv]
// Top level of the two-stack integer ALU: sequencer around data and control stack RAMs.
// Usage:
// A request on req_ carries one stack operation (req_op) and a literal used by
// push. A request is taken when req_valid is high and req_stall is low. Every
// request gives exactly one response on rsp_, taken when rsp_valid is high and
// rsp_stall is low; it reports the new data stack top, the value popped by emit,
// both stack depths and the underflow, overflow and divide-by-zero flags.
// Both stacks live in RAMs with a registered read port. One request is worked
// at a time: the sequencer reads the two top entries, computes, writes back (a
// second write for swap) and reads the new top before it puts the response out,
// and no new request is taken until it is back in its idle state.
// Divide waits in its own state for the divider's one-bit-per-cycle quotient loop.
// The response sits in an output register, so the next request is taken while
// the previous response still waits; a stalled receiver holds the response and
// the sequencer waits at its output step until the register frees up.
// Reset empties both stacks (counts to zero) and clears rsp_valid; the stack
// RAM contents are not cleared and no clearing pass is needed.
module two_stack_integer_alu (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [3:0]               req_op,
   input  logic signed [31:0]       req_literal,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_top_value,
   output logic signed [31:0]       rsp_emitted,
   output logic                     rsp_emit_valid,
   output tsalu_pkg::dcount_type    rsp_data_depth,
   output tsalu_pkg::ccount_type    rsp_control_depth,
   output logic                     rsp_underflow,
   output logic                     rsp_overflow,
   output logic                     rsp_divide_by_zero
);
   import tsalu_pkg::*;

   state_type   state_ff, state_in;
   logic [3:0]  op_ff, op_in;
   word_type    lit_ff, lit_in;
   word_type    i_ff, i_in;
   word_type    j_ff, j_in;
   word_type    res_ff, res_in;
   dcount_type  dcnt_ff, dcnt_in;
   ccount_type  ccnt_ff, ccnt_in;
   logic        under_ff, under_in;
   logic        over_ff, over_in;
   logic        dz_ff, dz_in;

   logic        rv_ff, rv_in;
   word_type    r_top_ff, r_top_in;
   word_type    r_emit_ff, r_emit_in;
   logic        r_ev_ff, r_ev_in;
   dcount_type  r_dd_ff, r_dd_in;
   ccount_type  r_cd_ff, r_cd_in;
   logic        r_un_ff, r_un_in;
   logic        r_ov_ff, r_ov_in;
   logic        r_dz_ff, r_dz_in;

   logic        d_we, d_re, c_we, c_re;
   logic [DAW-1:0] d_waddr, d_raddr;
   logic [CAW-1:0] c_waddr, c_raddr;
   word_type    d_wdata, c_wdata, d_rdata, c_rdata;
   dcount_type  dcnt_m1, dcnt_m2;
   ccount_type  ccnt_m1;
   logic        div_start;
   logic        div_done;
   word_type    div_q;

   logic [1:0]  npop;
   logic        npush;
   word_type    j_val;
   logic        req_accept, rsp_accept, is_from;

   tsalu_ram #(.WIDTH(WORD), .DEPTH(DATA_DEPTH)) u_data_ram (
      .clock(clock), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
      .re(d_re), .raddr(d_raddr), .rdata(d_rdata)
   );

   tsalu_ram #(.WIDTH(WORD), .DEPTH(CONTROL_DEPTH)) u_ctl_ram (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
      .re(c_re), .raddr(c_raddr), .rdata(c_rdata)
   );

   // The second operand is still on the RAM read port when the divider starts.
   tsalu_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(j_val), .divisor(i_ff), .done(div_done), .quotient(div_q)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rv_ff && !rsp_stall;
   assign is_from    = (op_ff == OP_FROMCTL);
   assign dcnt_m1    = dcnt_ff - dcount_type'(1);
   assign dcnt_m2    = dcnt_ff - dcount_type'(2);
   assign ccnt_m1    = ccnt_ff - ccount_type'(1);
   assign j_val      = (dcnt_ff >= dcount_type'(2)) ? d_rdata : '0;

   // Data stack pops and whether a push follows, per operation; swap's second push is its own write step.
   always_comb begin
      npop  = 2'd0;
      npush = 1'b0;
      unique case (op_ff)
         OP_PUSH:    npush = 1'b1;
         OP_DROP:    npop  = 2'd1;
         OP_DUP:     npush = 1'b1;
         OP_SWAP:    begin npop = 2'd2; npush = 1'b1; end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LT, OP_ULT:
                     begin npop = 2'd2; npush = 1'b1; end
         OP_NOT:     begin npop = 2'd1; npush = 1'b1; end
         OP_TOCTL:   npop  = 2'd1;
         OP_FROMCTL: npush = 1'b1;
         OP_EMIT:    npop  = 2'd1;
         default:    npush = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      lit_in   = lit_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      res_in   = res_ff;
      dcnt_in  = dcnt_ff;
      ccnt_in  = ccnt_ff;
      under_in = under_ff;
      over_in  = over_ff;
      dz_in    = dz_ff;
      rv_in     = rv_ff && !rsp_accept;
      r_top_in  = r_top_ff;
      r_emit_in = r_emit_ff;
      r_ev_in   = r_ev_ff;
      r_dd_in   = r_dd_ff;
      r_cd_in   = r_cd_ff;
      r_un_in   = r_un_ff;
      r_ov_in   = r_ov_ff;
      r_dz_in   = r_dz_ff;
      d_we = 1'b0; d_re = 1'b0; c_we = 1'b0; c_re = 1'b0;
      d_waddr = dcnt_ff[DAW-1:0];
      d_wdata = res_ff;
      d_raddr = dcnt_m1[DAW-1:0];
      c_waddr = ccnt_ff[CAW-1:0];
      c_wdata = i_ff;
      c_raddr = ccnt_m1[CAW-1:0];
      div_start = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               op_in    = req_op;
               lit_in   = word_type'(req_literal);
               under_in = 1'b0;
               over_in  = 1'b0;
               dz_in    = 1'b0;
               state_in = ST_RDI;
            end
         end
         ST_RDI: begin
            if (is_from) begin
               c_re = 1'b1;
            end else begin
               d_re = 1'b1;
            end
            state_in = ST_RDJ;
         end
         ST_RDJ: begin
            if (is_from) begin
               i_in = (ccnt_ff != '0) ? c_rdata : '0;
            end else begin
               i_in = (dcnt_ff != '0) ? d_rdata : '0;
            end
            d_re     = 1'b1;
            d_raddr  = dcnt_m2[DAW-1:0];
            state_in = ST_CALC;
         end
         ST_CALC: begin
            j_in = j_val;
            if (dcount_type'(npop) > dcnt_ff
                || (op_ff == OP_DUP && dcnt_ff == '0)
                || (is_from && ccnt_ff == '0)) begin
               under_in = 1'b1;
            end
            dcnt_in = (dcount_type'(npop) > dcnt_ff) ? '0 : dcnt_ff - dcount_type'(npop);
            if (is_from && ccnt_ff != '0) begin
               ccnt_in = ccnt_m1;
            end
            state_in = ST_WR1;
            unique case (op_ff)
               OP_PUSH: res_in = lit_ff;
               OP_ADD:  res_in = j_val + i_ff;
               OP_SUB:  res_in = j_val - i_ff;
               OP_MUL:  res_in = j_val * i_ff;
               OP_DIV: begin
                  res_in = '0;
                  if (i_ff == '0) begin
                     dz_in = 1'b1;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV;
                  end
               end
               OP_LT:   res_in = ($signed(j_val) < $signed(i_ff)) ? word_type'(1) : '0;
               OP_ULT:  res_in = (j_val < i_ff) ? word_type'(1) : '0;
               OP_NOT:  res_in = (i_ff == '0) ? word_type'(1) : '0;
               default: res_in = i_ff;
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = div_q;
               state_in = ST_WR1;
            end
         end
         ST_WR1: begin
            if (npush) begin
               if (dcnt_ff < dcount_type'(DATA_DEPTH)) begin
                  d_we    = 1'b1;
                  dcnt_in = dcnt_ff + dcount_type'(1);
               end else begin
                  over_in = 1'b1;
               end
            end
            if (op_ff == OP_TOCTL) begin
               if (ccnt_ff < ccount_type'(CONTROL_DEPTH)) begin
                  c_we    = 1'b1;
                  ccnt_in = ccnt_ff + ccount_type'(1);
               end else begin
                  over_in = 1'b1;
               end
            end
            state_in = (op_ff == OP_SWAP) ? ST_WR2 : ST_RDTOP;
         end
         ST_WR2: begin
            d_wdata = j_ff;
            if (dcnt_ff < dcount_type'(DATA_DEPTH)) begin
               d_we    = 1'b1;
               dcnt_in = dcnt_ff + dcount_type'(1);
            end else begin
               over_in = 1'b1;
            end
            state_in = ST_RDTOP;
         end
         ST_RDTOP: begin
            d_re     = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // The response register must be free, or freed this cycle.
            if (!rv_ff || rsp_accept) begin
               rv_in     = 1'b1;
               r_top_in  = (dcnt_ff != '0) ? d_rdata : '0;
               r_emit_in = (op_ff == OP_EMIT) ? i_ff : '0;
               r_ev_in   = (op_ff == OP_EMIT);
               r_dd_in   = dcnt_ff;
               r_cd_in   = ccnt_ff;
               r_un_in   = under_ff;
               r_ov_in   = over_ff;
               r_dz_in   = dz_ff;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dcnt_ff  <= '0;
         ccnt_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dcnt_ff  <= dcnt_in;
         ccnt_ff  <= ccnt_in;
         rv_ff    <= rv_in;
      end
      op_ff     <= op_in;
      lit_ff    <= lit_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      res_ff    <= res_in;
      under_ff  <= under_in;
      over_ff   <= over_in;
      dz_ff     <= dz_in;
      r_top_ff  <= r_top_in;
      r_emit_ff <= r_emit_in;
      r_ev_ff   <= r_ev_in;
      r_dd_ff   <= r_dd_in;
      r_cd_ff   <= r_cd_in;
      r_un_ff   <= r_un_in;
      r_ov_ff   <= r_ov_in;
      r_dz_ff   <= r_dz_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_top_value      = $signed(r_top_ff);
   assign rsp_emitted        = $signed(r_emit_ff);
   assign rsp_emit_valid     = r_ev_ff;
   assign rsp_data_depth     = r_dd_ff;
   assign rsp_control_depth  = r_cd_ff;
   assign rsp_underflow      = r_un_ff;
   assign rsp_overflow       = r_ov_ff;
   assign rsp_divide_by_zero = r_dz_ff;

   a_data_count_bound: assert property (@(posedge clock) disable iff (reset)
      dcnt_ff <= dcount_type'(DATA_DEPTH))
      else $error("data stack count beyond its depth");
   a_ctl_count_bound: assert property (@(posedge clock) disable iff (reset)
      ccnt_ff <= ccount_type'(CONTROL_DEPTH))
      else $error("control stack count beyond its depth");
   a_accept_starts_read: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_RDI)
      else $error("accepted request did not start the read step");
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide wait");
   a_no_write_collision: assert property (@(posedge clock) disable iff (reset)
      d_we |-> !d_re)
      else $error("data stack read and write in the same cycle");
endmodule
